/* design/mmq_pkg.sv */
// Shared widths, opcodes and constants for the min/max byte quantizer.
package mmq_pkg;

  // Fixed field widths
  localparam int OPCODE_W    = 2;
  localparam int SAMPLE_W    = 16;
  localparam int CODE_W      = 8;
  localparam int SCALE_OUT_W = 26;
  localparam int BIAS_OUT_W  = 33;

  // APB register file
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;
  localparam int REG_BAD_CODE = 0;

  typedef logic [OPCODE_W-1:0]        opcode_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CODE_W-1:0]          code_t;
  typedef logic signed [SCALE_OUT_W-1:0] scale_out_t;
  typedef logic signed [BIAS_OUT_W-1:0]  bias_out_t;

  // Opcodes
  localparam opcode_t OP_SCAN   = 2'd0;
  localparam opcode_t OP_FINISH = 2'd1;
  localparam opcode_t OP_QUANT  = 2'd2;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_CODE   = 1'b1;

  // Tracker and register reset values
  localparam sample_t MIN_INIT      = 16'sh7FFF;
  localparam sample_t MAX_INIT      = 16'sh8000;
  localparam sample_t BAD_CODE_INIT = 16'sh8000;

  // Range is spread over this many steps; largest code
  localparam int RANGE_STEPS = 250;
  localparam int CODE_MAX    = 255;

endpackage

/* design/mmq_in_if.sv */
// Input channel: opcode and sample word with valid/ready handshake.
interface mmq_in_if
  import mmq_pkg::*;
;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  sample_t sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

/* design/mmq_out_if.sv */
// Output channel: quantized byte or scale/bias report with valid/ready handshake.
interface mmq_out_if
  import mmq_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       result_kind;
  code_t      code;
  logic       saturated;
  scale_out_t scale_out;
  bias_out_t  bias_out;

  modport source (output valid, output result_kind, output code, output saturated,
                  output scale_out, output bias_out, input ready);
  modport sink   (input valid, input result_kind, input code, input saturated,
                  input scale_out, input bias_out, output ready);
endinterface

/* design/minmax_byte_quantizer_core.sv */
// Min/max byte quantizer: scan, finish and quantize on one bit-serial divider.
// A scan word folds the sample into the running minimum and maximum (the
// bad-sample code is skipped); the next word may follow at once. Finish and
// quantize words go through one shared restoring divider that retires one
// quotient bit per cycle over FRAC_BITS+18 bits. A quantize word passes the
// prepare, absolute-value, divide and finish states, and its code is
// registered as it leaves the finish state; a finish word goes on to a
// bias-update state, which registers the report.
// Input is taken only while no divide is running. A finished result waits in
// the output register; scan words keep flowing meanwhile, and a divide that
// completes while the register is still full holds until it drains.
// Scale and bias are Q(FRAC_BITS) two's complement; bad_code is at APB address
// 0x0. Write it only while the block is idle; the block does not enforce this.
module minmax_byte_quantizer_core
  import mmq_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  mmq_in_if.sink            feed,
  mmq_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Internal widths
  localparam int SCW  = FRAC_BITS + 10;   // signed scale
  localparam int BW   = FRAC_BITS + 17;   // signed bias
  localparam int NW   = FRAC_BITS + 18;   // signed numerator, quotient steps
  localparam int DVW  = SCW;              // divisor magnitude
  localparam int CW   = $clog2(NW);
  localparam int TINY = (1 << FRAC_BITS) / 10000;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_BIAS = 3'd5;

  logic [2:0]            state;
  sample_t               bad_code;
  sample_t               running_min;
  sample_t               running_max;
  logic signed [SCW-1:0] scale_reg;
  logic signed [BW-1:0]  bias_reg;

  opcode_t               op_lat;
  sample_t               sample_lat;
  logic                  bad_lat;
  logic signed [NW-1:0]  num;
  logic                  q_neg;
  logic [NW-1:0]         dvd;
  logic [DVW-1:0]        divisor;
  logic [DVW-1:0]        rem;
  logic [CW-1:0]         cnt;
  logic signed [SCW-1:0] sc_new;

  logic                  out_valid;
  logic                  out_kind;
  code_t                 out_code;
  logic                  out_sat;
  logic signed [SCW-1:0] out_scale;
  logic signed [BW-1:0]  out_bias;

  logic                  cfg_write;
  logic                  in_take;
  logic                  out_free;
  logic [DVW:0]          trial;
  logic                  trial_ok;
  logic [DVW:0]          trial_diff;
  logic                  is_quant;
  logic signed [SCW-1:0] sc_calc;
  logic signed [BW-1:0]  bias_calc;
  code_t                 q_code;
  logic                  q_sat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == 1'(REG_BAD_CODE)) ? APB_DW'(bad_code) : '0;

  assign feed.ready = (state == ST_IDLE);
  assign in_take    = feed.valid && feed.ready;
  assign out_free   = !out_valid || result.ready;
  assign is_quant   = (op_lat == OP_QUANT);

  // One restoring step: bring down the next dividend bit and try the divisor
  assign trial      = {rem, dvd[NW-1]};
  assign trial_ok   = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  // Finish: signed scale from quotient, tiny magnitudes become 1.0
  always_comb begin
    sc_calc = q_neg ? -SCW'(dvd) : SCW'(dvd);
    if (dvd <= NW'(TINY)) begin
      sc_calc = SCW'(1) <<< FRAC_BITS;
    end
  end

  assign bias_calc = (BW'(running_min) <<< FRAC_BITS) - (BW'(sc_new) <<< 1);

  // Quantize: clamp the truncated quotient to a byte; a bad sample gives code 0
  always_comb begin
    q_code = '0;
    q_sat  = 1'b0;
    priority if (bad_lat || dvd == '0) begin
      q_code = '0;
    end else if (q_neg) begin
      q_sat = 1'b1;
    end else if (dvd > NW'(CODE_MAX)) begin
      q_code = code_t'(CODE_MAX);
      q_sat  = 1'b1;
    end else begin
      q_code = dvd[CODE_W-1:0];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_code <= BAD_CODE_INIT;
    end else if (cfg_write && paddr[2] == 1'(REG_BAD_CODE)) begin
      bad_code <= pwdata[SAMPLE_W-1:0];
    end
  end

  // Sequencer, trackers and scale/bias state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_min <= MIN_INIT;
      running_max <= MAX_INIT;
      scale_reg   <= SCW'(1) <<< FRAC_BITS;
      bias_reg    <= '0;
      cnt         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            op_lat     <= feed.opcode;
            sample_lat <= feed.sample;
            bad_lat    <= (feed.sample == bad_code);
            if (feed.opcode == OP_SCAN) begin
              if (feed.sample != bad_code) begin
                if (feed.sample > running_max) running_max <= feed.sample;
                if (feed.sample < running_min) running_min <= feed.sample;
              end
            end else if (feed.opcode == OP_FINISH || feed.opcode == OP_QUANT) begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          // Form the signed numerator
          if (is_quant) begin
            num <= (NW'(sample_lat) <<< FRAC_BITS) - NW'(bias_reg);
          end else begin
            num <= (NW'(running_max) - NW'(running_min)) <<< FRAC_BITS;
          end
          state <= ST_ABS;
        end
        ST_ABS: begin
          // Split into magnitudes and a quotient sign
          dvd <= num[NW-1] ? NW'(-num) : NW'(num);
          rem <= '0;
          cnt <= '0;
          if (is_quant) begin
            divisor <= scale_reg[SCW-1] ? DVW'(-scale_reg) : DVW'(scale_reg);
            q_neg   <= num[NW-1] ^ scale_reg[SCW-1];
          end else begin
            divisor <= DVW'(RANGE_STEPS);
            q_neg   <= num[NW-1];
          end
          state <= ST_DIV;
        end
        ST_DIV: begin
          // Advance one quotient bit
          rem <= trial_ok ? trial_diff[DVW-1:0] : trial[DVW-1:0];
          dvd <= {dvd[NW-2:0], trial_ok};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!is_quant) begin
            sc_new <= sc_calc;
            state  <= ST_BIAS;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_BIAS: begin
          // Commit scale and bias, rearm the trackers
          if (out_free) begin
            scale_reg   <= sc_new;
            bias_reg    <= bias_calc;
            running_min <= MIN_INIT;
            running_max <= MAX_INIT;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && is_quant && out_free) begin
      out_valid <= 1'b1;
      out_kind  <= KIND_CODE;
      out_code  <= q_code;
      out_sat   <= q_sat;
      out_scale <= scale_reg;
      out_bias  <= bias_reg;
    end else if (state == ST_BIAS && out_free) begin
      out_valid <= 1'b1;
      out_kind  <= KIND_REPORT;
      out_code  <= '0;
      out_sat   <= 1'b0;
      out_scale <= sc_new;
      out_bias  <= bias_calc;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid       = out_valid;
  assign result.result_kind = out_kind;
  assign result.code        = out_code;
  assign result.saturated   = out_sat;
  assign result.scale_out   = SCALE_OUT_W'(out_scale);
  assign result.bias_out    = BIAS_OUT_W'(out_bias);

endmodule
